[sv/ctpd_pkg.sv]
// ----------------------------------------------------------------------------
// ctpd_pkg: shared definitions for the carrier tracking loop
// Holds the default sizes, register reset values, the CORDIC arctangent table,
// the controller state encoding and the command word sent to the datapath.
// ----------------------------------------------------------------------------
package ctpd_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int PHASE_WIDTH_DEF  = 16;

	// CORDIC iteration count and the width of its step index.
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 4;

	// 0.60725293 in Q1.30, the start value of the oscillator CORDIC.
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

	// Configuration register map.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_GAIN     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY_GAIN = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY_LIM  = 2'd2;

	localparam logic [15:0] PHASE_GAIN_RST     = 16'd6554;
	localparam logic [15:0] FREQUENCY_GAIN_RST = 16'd328;
	localparam logic [14:0] FREQUENCY_LIM_RST  = 15'd1043;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CORDIC,
		S_FINISH,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_MUL4,
		S_MUL5,
		S_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CORDIC,
		OP_FINISH,
		OP_MUL1,
		OP_MUL2,
		OP_MUL3,
		OP_MUL4,
		OP_MUL5,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	// Arctangent of 2^-k as a fraction of a turn, 2^32 = one turn.
	function automatic logic [31:0] atan_turn32(input logic [STEP_W-1:0] k);
		logic [31:0] v;
		unique case (k)
			4'd0:  v = 32'd536870912;
			4'd1:  v = 32'd316933406;
			4'd2:  v = 32'd167458907;
			4'd3:  v = 32'd85004756;
			4'd4:  v = 32'd42667331;
			4'd5:  v = 32'd21354465;
			4'd6:  v = 32'd10680350;
			4'd7:  v = 32'd5340245;
			4'd8:  v = 32'd2670163;
			4'd9:  v = 32'd1335087;
			4'd10: v = 32'd667544;
			4'd11: v = 32'd333772;
			4'd12: v = 32'd166886;
			4'd13: v = 32'd83443;
			4'd14: v = 32'd41722;
			4'd15: v = 32'd20861;
		endcase
		return v;
	endfunction

endpackage

[sv/carrier_tracking_pll_demod.sv]
// ----------------------------------------------------------------------------
// carrier_tracking_pll_demod: second-order carrier tracking loop
// Mixes each complex sample with a local oscillator, emits the quadrature
// product and steers the oscillator from an arctangent phase detector.
// ----------------------------------------------------------------------------
// One input transfer carries a complex sample and yields exactly one result
// transfer, demod_value = round((q*cos - i*sin) / 2^15) saturated to
// SAMPLE_WIDTH+1 bits, where cos and sin come from the oscillator phase held
// before the sample. The block takes one sample at a time and holds off the
// next input transfer until its steps are done: accepting it, 16 iterations
// of the two CORDIC units (oscillator sine/cosine and sample arctangent,
// stepped together), rounding the CORDIC outputs and forming the phase
// error, five steps of the single shared multiplier (q*cos, i*sin,
// error*frequency_gain, error*phase_gain with the phase update last) and
// moving the result into the output register. The output register lets
// the next sample enter while a result still waits downstream; if it has
// not left when the next result is ready, the block holds. Phase is a
// PHASE_WIDTH-bit fraction of a full turn and wraps; the frequency
// integrator is clipped to frequency_limit. The configuration port is always
// ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module carrier_tracking_pll_demod #(
	parameter int SAMPLE_WIDTH = ctpd_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_WIDTH  = ctpd_pkg::PHASE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Sample channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]   sample_i,
	input  logic signed [SAMPLE_WIDTH-1:0]   sample_q,
	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_WIDTH:0]     demod_value,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctpd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data
);

	ctpd_pkg::dp_cmd_t cmd;

	// The configuration registers accept every write, so the port never holds off.
	assign cfg_ready = 1'b1;

	// The controller sequences one sample at a time and owns both handshakes.
	ctpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// The datapath holds the oscillator state, the gains and all arithmetic.
	ctpd_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.PHASE_WIDTH  (PHASE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_i    (sample_i),
		.sample_q    (sample_q),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.demod_value (demod_value)
	);

endmodule

[sv/ctpd_ctrl.sv]
// ----------------------------------------------------------------------------
// ctpd_ctrl: sequencer of the carrier tracking loop
// Steps one sample through the CORDIC iterations and the multiply steps and
// owns both handshakes.
// ----------------------------------------------------------------------------
module ctpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ctpd_pkg::dp_cmd_t cmd
);

	localparam logic [ctpd_pkg::STEP_W-1:0] LAST_STEP =
		ctpd_pkg::STEP_W'(ctpd_pkg::CORDIC_STEPS - 1);

	ctpd_pkg::state_t state_q, state_nxt;
	logic [ctpd_pkg::STEP_W-1:0] step_q;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ctpd_pkg::S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ctpd_pkg::S_CORDIC) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (cmd.op == ctpd_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = ctpd_pkg::OP_NONE;
		cmd.step  = step_q;
		unique case (state_q)
			ctpd_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.op    = ctpd_pkg::OP_LOAD;
					state_nxt = ctpd_pkg::S_CORDIC;
				end
			end
			ctpd_pkg::S_CORDIC: begin
				cmd.op = ctpd_pkg::OP_CORDIC;
				if (step_q == LAST_STEP) begin
					state_nxt = ctpd_pkg::S_FINISH;
				end
			end
			ctpd_pkg::S_FINISH: begin
				cmd.op    = ctpd_pkg::OP_FINISH;
				state_nxt = ctpd_pkg::S_MUL1;
			end
			ctpd_pkg::S_MUL1: begin
				cmd.op    = ctpd_pkg::OP_MUL1;
				state_nxt = ctpd_pkg::S_MUL2;
			end
			ctpd_pkg::S_MUL2: begin
				cmd.op    = ctpd_pkg::OP_MUL2;
				state_nxt = ctpd_pkg::S_MUL3;
			end
			ctpd_pkg::S_MUL3: begin
				cmd.op    = ctpd_pkg::OP_MUL3;
				state_nxt = ctpd_pkg::S_MUL4;
			end
			ctpd_pkg::S_MUL4: begin
				cmd.op    = ctpd_pkg::OP_MUL4;
				state_nxt = ctpd_pkg::S_MUL5;
			end
			ctpd_pkg::S_MUL5: begin
				cmd.op    = ctpd_pkg::OP_MUL5;
				state_nxt = ctpd_pkg::S_OUT;
			end
			ctpd_pkg::S_OUT: begin
				// The output register is free, or its result leaves this cycle.
				if (!out_valid_q || !out_stall) begin
					cmd.op    = ctpd_pkg::OP_OUT;
					state_nxt = ctpd_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = ctpd_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ctpd_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[sv/ctpd_datapath.sv]
// ----------------------------------------------------------------------------
// ctpd_datapath: arithmetic of the carrier tracking loop
// Two CORDIC units (oscillator sine/cosine and sample arctangent), one shared
// multiplier, the loop state and the configuration registers.
// ----------------------------------------------------------------------------
module ctpd_datapath #(
	parameter int SAMPLE_WIDTH = ctpd_pkg::SAMPLE_WIDTH_DEF,
	parameter int PHASE_WIDTH  = ctpd_pkg::PHASE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ctpd_pkg::dp_cmd_t                   cmd,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample_q,
	input  logic                                cfg_we,
	input  logic [ctpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [15:0]                         cfg_data,
	output logic signed [SAMPLE_WIDTH:0]        demod_value
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int PW    = PHASE_WIDTH;
	localparam int OW    = SW + 1;
	localparam int CW    = 34;
	localparam int SCL   = 31 - SW;
	localparam int SH    = 32 - PW;
	localparam int MA    = (SW > PW) ? SW : PW;
	localparam int MB    = 18;
	localparam int PRODW = MA + MB;
	localparam int ACCW  = PRODW + 1;
	localparam int GW    = PRODW + 1;

	localparam logic [31:0] ANG_HALF = (32'd1 << SH) >> 1;
	localparam logic signed [CW-1:0] C_RND = CW'(16384);
	localparam logic signed [ACCW-1:0] D_RND = ACCW'(16384);
	localparam logic signed [ACCW-1:0] D_MAX = ACCW'((64'sd1 <<< SW) - 64'sd1);
	localparam logic signed [ACCW-1:0] D_MIN = ~D_MAX;
	localparam logic signed [GW-1:0] G_RND = GW'(32768);
	localparam logic signed [GW-1:0] LIM_MAX = GW'((64'sd1 <<< (PW - 1)) - 64'sd1);

	// Configuration.
	logic [15:0] phase_gain_q;
	logic [15:0] frequency_gain_q;
	logic [14:0] frequency_limit_q;

	// Loop state.
	logic [PW-1:0]        phase_q;
	logic signed [PW-1:0] freq_q;

	// Sample and CORDIC registers.
	logic signed [SW-1:0] i_q, q_q;
	logic                 zero_q, flip_q;
	logic signed [CW-1:0] rx_q, ry_q, rz_q;
	logic signed [CW-1:0] vx_q, vy_q;
	logic [31:0]          vz_q;

	// Multiply stage registers.
	logic signed [MB-1:0]    c_q, s_q;
	logic signed [PW-1:0]    err_q;
	logic signed [PRODW-1:0] prod_q, acc_q;
	logic signed [OW-1:0]    dem_q, out_q;

	// Combinational terms.
	logic [31:0]          rot_a, rot_a_q1;
	logic                 rot_flip;
	logic signed [CW-1:0] ix, iy;
	logic signed [CW-1:0] r_dx, r_dy, v_dx, v_dy, atan_w;
	logic signed [CW-1:0] xs, ys, cs, ss;
	logic [31:0]          vz_rnd;
	logic [PW-1:0]        ang;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PRODW-1:0] mul_p;
	logic signed [ACCW-1:0]  dsum, dsh, dsat;
	logic signed [GW-1:0]    adj, fsum, lim, flim, fclip;

	always_comb begin
		rot_a    = 32'(phase_q) << SH;
		rot_a_q1 = rot_a + 32'h4000_0000;
		rot_flip = rot_a_q1[31];
		ix       = CW'(sample_i) <<< SCL;
		iy       = CW'(sample_q) <<< SCL;
		atan_w   = CW'(ctpd_pkg::atan_turn32(cmd.step));
		r_dx     = ry_q >>> cmd.step;
		r_dy     = rx_q >>> cmd.step;
		v_dx     = vy_q >>> cmd.step;
		v_dy     = vx_q >>> cmd.step;
		xs       = flip_q ? -rx_q : rx_q;
		ys       = flip_q ? -ry_q : ry_q;
		cs       = (xs + C_RND) >>> 15;
		ss       = (ys + C_RND) >>> 15;
		vz_rnd   = vz_q + ANG_HALF;
		ang      = zero_q ? '0 : vz_rnd[31:SH];
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			ctpd_pkg::OP_MUL1: begin
				mul_a = MA'(q_q);
				mul_b = c_q;
			end
			ctpd_pkg::OP_MUL2: begin
				mul_a = MA'(i_q);
				mul_b = s_q;
			end
			ctpd_pkg::OP_MUL3: begin
				mul_a = MA'(err_q);
				mul_b = $signed({2'b00, frequency_gain_q});
			end
			ctpd_pkg::OP_MUL4: begin
				mul_a = MA'(err_q);
				mul_b = $signed({2'b00, phase_gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Demodulated value and loop filter terms.
	always_comb begin
		dsum = ACCW'(acc_q) - ACCW'(prod_q) + D_RND;
		dsh  = dsum >>> 15;
		if (dsh > D_MAX) begin
			dsat = D_MAX;
		end else if (dsh < D_MIN) begin
			dsat = D_MIN;
		end else begin
			dsat = dsh;
		end
		adj  = (GW'(prod_q) + G_RND) >>> 16;
		fsum = GW'(freq_q) + adj;
		lim  = GW'($signed({1'b0, frequency_limit_q}));
		flim = (lim > LIM_MAX) ? LIM_MAX : lim;
		if (fsum > flim) begin
			fclip = flim;
		end else if (fsum < -flim) begin
			fclip = -flim;
		end else begin
			fclip = fsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_gain_q      <= ctpd_pkg::PHASE_GAIN_RST;
			frequency_gain_q  <= ctpd_pkg::FREQUENCY_GAIN_RST;
			frequency_limit_q <= ctpd_pkg::FREQUENCY_LIM_RST;
			phase_q           <= '0;
			freq_q            <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ctpd_pkg::CFG_PHASE_GAIN:     phase_gain_q      <= cfg_data;
					ctpd_pkg::CFG_FREQUENCY_GAIN: frequency_gain_q  <= cfg_data;
					ctpd_pkg::CFG_FREQUENCY_LIM:  frequency_limit_q <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.op == ctpd_pkg::OP_MUL4) begin
				freq_q <= fclip[PW-1:0];
			end
			if (cmd.op == ctpd_pkg::OP_MUL5) begin
				phase_q <= phase_q + adj[PW-1:0] + freq_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ctpd_pkg::OP_LOAD: begin
				i_q    <= sample_i;
				q_q    <= sample_q;
				zero_q <= (sample_i == '0) && (sample_q == '0);
				// Oscillator angle folded into the right half plane.
				flip_q <= rot_flip;
				rx_q   <= CW'(ctpd_pkg::CORDIC_GAIN_Q30);
				ry_q   <= '0;
				rz_q   <= CW'($signed(rot_flip ? rot_a + 32'h8000_0000 : rot_a));
				// Sample mirrored into the right half plane for vectoring.
				if (ix < 0) begin
					vx_q <= -ix;
					vy_q <= -iy;
					vz_q <= 32'h8000_0000;
				end else begin
					vx_q <= ix;
					vy_q <= iy;
					vz_q <= '0;
				end
			end
			ctpd_pkg::OP_CORDIC: begin
				if (rz_q >= 0) begin
					rx_q <= rx_q - r_dx;
					ry_q <= ry_q + r_dy;
					rz_q <= rz_q - atan_w;
				end else begin
					rx_q <= rx_q + r_dx;
					ry_q <= ry_q - r_dy;
					rz_q <= rz_q + atan_w;
				end
				if (vy_q > 0) begin
					vx_q <= vx_q + v_dx;
					vy_q <= vy_q - v_dy;
					vz_q <= vz_q + atan_w[31:0];
				end else begin
					vx_q <= vx_q - v_dx;
					vy_q <= vy_q + v_dy;
					vz_q <= vz_q - atan_w[31:0];
				end
			end
			ctpd_pkg::OP_FINISH: begin
				c_q   <= cs[MB-1:0];
				s_q   <= ss[MB-1:0];
				err_q <= $signed(ang - phase_q);
			end
			ctpd_pkg::OP_MUL1: begin
				prod_q <= mul_p;
			end
			ctpd_pkg::OP_MUL2: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			ctpd_pkg::OP_MUL3: begin
				dem_q  <= dsat[OW-1:0];
				prod_q <= mul_p;
			end
			ctpd_pkg::OP_MUL4: begin
				prod_q <= mul_p;
			end
			ctpd_pkg::OP_OUT: begin
				out_q <= dem_q;
			end
			default: ;
		endcase
	end

	assign demod_value = out_q;

endmodule

[sv/ctpd_checker.sv]
// ----------------------------------------------------------------------------
// ctpd_checker: port-level checks of the carrier tracking loop
// Watches the handshakes of the top level over time.
// ----------------------------------------------------------------------------
module ctpd_checker #(
	parameter int SAMPLE_WIDTH = ctpd_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_WIDTH:0]  demod_value
);

	// A result held back downstream stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(demod_value))
		else $error("result changed or vanished while stalled");

	// An accepted sample keeps the block busy through its CORDIC iterations.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##16 in_stall)
		else $error("block took a new sample too early");

	// A new result is only produced while the block is working on a sample.
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a sample in progress");

	// Returning to idle always leaves a result waiting.
	a_idle_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("block went idle without presenting its result");

endmodule

bind carrier_tracking_pll_demod ctpd_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ctpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.demod_value (demod_value)
);
